// ===== rtl/vfld_pkg.sv =====
package vfld_pkg;

  // Default number of texture coordinate sets handled
  localparam int unsigned MaxTexSets = 8;

  // Fixed slots, in emission order; texture sets follow from SlotTex0
  localparam int unsigned SlotPos      = 0;
  localparam int unsigned SlotWeight   = 1;
  localparam int unsigned SlotIndices  = 2;
  localparam int unsigned SlotNormal   = 3;
  localparam int unsigned SlotPsize    = 4;
  localparam int unsigned SlotDiffuse  = 5;
  localparam int unsigned SlotSpecular = 6;
  localparam int unsigned SlotTex0     = 7;

  // Format word bit positions
  localparam int unsigned PosLsb       = 1;
  localparam int unsigned NormalBit    = 4;
  localparam int unsigned PsizeBit     = 5;
  localparam int unsigned DiffuseBit   = 6;
  localparam int unsigned SpecularBit  = 7;
  localparam int unsigned TexCountLsb  = 8;
  localparam int unsigned Ubyte4Bit    = 12;
  localparam int unsigned TexSizeBase  = 16;

  // Position codes (bits 3..1 of the format word)
  localparam logic [2:0] POS_NONE   = 3'd0;
  localparam logic [2:0] POS_XYZ    = 3'd1;
  localparam logic [2:0] POS_XYZRHW = 3'd2;
  localparam logic [2:0] POS_BLEND1 = 3'd3;

  // Texture set size code meaning one float
  localparam logic [1:0] TEX_ONE_FLOAT = 2'd3;

  // Element kinds
  localparam logic [2:0] KIND_POSITION     = 3'd0;
  localparam logic [2:0] KIND_BLENDWEIGHT  = 3'd1;
  localparam logic [2:0] KIND_BLENDINDICES = 3'd2;
  localparam logic [2:0] KIND_NORMAL       = 3'd3;
  localparam logic [2:0] KIND_PSIZE        = 3'd4;
  localparam logic [2:0] KIND_COLOR        = 3'd5;
  localparam logic [2:0] KIND_TEXCOORD     = 3'd6;

  // Element formats
  localparam logic [2:0] FMT_FLOAT1  = 3'd0;
  localparam logic [2:0] FMT_FLOAT2  = 3'd1;
  localparam logic [2:0] FMT_FLOAT3  = 3'd2;
  localparam logic [2:0] FMT_FLOAT4  = 3'd3;
  localparam logic [2:0] FMT_UINT8X4 = 3'd4;
  localparam logic [2:0] FMT_BGRA8   = 3'd5;

  // Float count to format; five floats has no code and maps to two floats
  function automatic logic [2:0] fmt_for_floats(input logic [2:0] count);
    logic [2:0] fmt;
    if (count >= 3'd1 && count <= 3'd4) begin
      fmt = count - 3'd1;
    end else begin
      fmt = FMT_FLOAT2;
    end
    return fmt;
  endfunction

endpackage

// ===== rtl/vertex_format_layout_decoder.sv =====
// Vertex format layout decoder.
// A format word is offered on format_word with start; the transaction is taken
// at a rising edge where start is high and busy is low. The block then emits
// one result per element of the vertex layout, in layout order, each on the
// result ports for exactly one cycle with result_valid high; last_element
// marks the final result of a word. A word with no position gives a single
// result with layout_valid low.
// The first result of a word passes through the capture, decode, element walk and
// output registers. Throughput: a word with n elements (1 to 7 + MAX_TEXCOORD_SETS)
// occupies the element walker, one element per cycle; capture and decode stages
// run ahead, so back-to-back words stream with no gap between them.
// busy rises only when both front stages hold words waiting on the walker.
// Reset (rst, synchronous) empties every stage and drops result_valid.
// The receiver cannot stall: every result is taken in its strobe cycle.
module vertex_format_layout_decoder #(
  parameter int unsigned MAX_TEXCOORD_SETS = vfld_pkg::MaxTexSets
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] format_word,
  output logic        result_valid,
  output logic        layout_valid,
  output logic [2:0]  element_kind,
  output logic [2:0]  semantic_slot,
  output logic [2:0]  element_format,
  output logic [7:0]  byte_offset,
  output logic [4:0]  elem_size,
  output logic [7:0]  total_stride,
  output logic        last_element
);

  localparam int unsigned NumSlots = vfld_pkg::SlotTex0 + MAX_TEXCOORD_SETS;
  localparam int unsigned SlotW    = $clog2(NumSlots);

  // Stage handshake
  logic              cap_valid;
  logic [31:0]       cap_word;
  logic              dec_valid;
  logic [NumSlots-1:0] dec_mask;
  logic [2:0]        dec_fmt  [NumSlots];
  logic [4:0]        dec_size [NumSlots];
  logic              dec_layout;
  logic              walk_valid;
  logic [NumSlots-1:0] walk_mask;
  logic [2:0]        walk_fmt  [NumSlots];
  logic [4:0]        walk_size [NumSlots];
  logic              walk_layout;
  logic [7:0]        walk_stride;

  logic              walk_last;
  logic              walk_free;
  logic              dec_take;
  logic              dec_free;
  logic              cap_take;
  logic              cap_free;
  logic              accept;

  assign walk_free = !walk_valid || walk_last;
  assign dec_take  = dec_valid && walk_free;
  assign dec_free  = !dec_valid || walk_free;
  assign cap_take  = cap_valid && dec_free;
  assign cap_free  = !cap_valid || dec_free;
  assign busy      = !cap_free;
  assign accept    = start && !busy;

  // Capture stage
  always_ff @(posedge clk) begin
    if (rst) begin
      cap_valid <= 1'b0;
    end else if (accept) begin
      cap_valid <= 1'b1;
    end else if (cap_take) begin
      cap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cap_word <= format_word;
    end
  end

  // Decode: presence, format and size of every slot
  logic [NumSlots-1:0] d_mask;
  logic [2:0]          d_fmt  [NumSlots];
  logic [4:0]          d_size [NumSlots];
  logic                d_layout;
  logic [2:0]          pos_code;
  logic [2:0]          betas;
  logic [2:0]          wf;
  logic [3:0]          set_count;
  logic [1:0]          tex_bits;
  logic [2:0]          tex_floats;

  always_comb begin
    pos_code   = cap_word[vfld_pkg::PosLsb +: 3];
    betas      = pos_code - 3'd2;
    wf         = betas - 3'd1;
    set_count  = cap_word[vfld_pkg::TexCountLsb +: 4];
    tex_bits   = 2'd0;
    tex_floats = 3'd0;
    d_mask     = '0;
    d_layout   = 1'b1;
    for (int i = 0; i < NumSlots; i++) begin
      d_fmt[i]  = vfld_pkg::FMT_FLOAT1;
      d_size[i] = 5'd0;
    end

    // Position
    d_mask[vfld_pkg::SlotPos] = 1'b1;
    if (pos_code == vfld_pkg::POS_XYZRHW) begin
      d_fmt[vfld_pkg::SlotPos]  = vfld_pkg::FMT_FLOAT4;
      d_size[vfld_pkg::SlotPos] = 5'd16;
    end else begin
      d_fmt[vfld_pkg::SlotPos]  = vfld_pkg::FMT_FLOAT3;
      d_size[vfld_pkg::SlotPos] = 5'd12;
    end

    // Blend weights and packed indices
    if (pos_code >= vfld_pkg::POS_BLEND1) begin
      if (cap_word[vfld_pkg::Ubyte4Bit]) begin
        d_mask[vfld_pkg::SlotWeight]   = (wf != 3'd0);
        d_fmt[vfld_pkg::SlotWeight]    = vfld_pkg::fmt_for_floats(wf);
        d_size[vfld_pkg::SlotWeight]   = {wf, 2'b00};
        d_mask[vfld_pkg::SlotIndices]  = 1'b1;
        d_fmt[vfld_pkg::SlotIndices]   = vfld_pkg::FMT_UINT8X4;
        d_size[vfld_pkg::SlotIndices]  = 5'd4;
      end else begin
        d_mask[vfld_pkg::SlotWeight]   = 1'b1;
        d_fmt[vfld_pkg::SlotWeight]    = vfld_pkg::fmt_for_floats(betas);
        d_size[vfld_pkg::SlotWeight]   = {betas, 2'b00};
      end
    end

    // Fixed attributes
    d_mask[vfld_pkg::SlotNormal]   = cap_word[vfld_pkg::NormalBit];
    d_fmt[vfld_pkg::SlotNormal]    = vfld_pkg::FMT_FLOAT3;
    d_size[vfld_pkg::SlotNormal]   = 5'd12;
    d_mask[vfld_pkg::SlotPsize]    = cap_word[vfld_pkg::PsizeBit];
    d_fmt[vfld_pkg::SlotPsize]     = vfld_pkg::FMT_FLOAT1;
    d_size[vfld_pkg::SlotPsize]    = 5'd4;
    d_mask[vfld_pkg::SlotDiffuse]  = cap_word[vfld_pkg::DiffuseBit];
    d_fmt[vfld_pkg::SlotDiffuse]   = vfld_pkg::FMT_BGRA8;
    d_size[vfld_pkg::SlotDiffuse]  = 5'd4;
    d_mask[vfld_pkg::SlotSpecular] = cap_word[vfld_pkg::SpecularBit];
    d_fmt[vfld_pkg::SlotSpecular]  = vfld_pkg::FMT_BGRA8;
    d_size[vfld_pkg::SlotSpecular] = 5'd4;

    // Texture sets; counts above the slot count saturate naturally
    for (int i = 0; i < MAX_TEXCOORD_SETS; i++) begin
      tex_bits   = cap_word[vfld_pkg::TexSizeBase + 2 * i +: 2];
      tex_floats = (tex_bits == vfld_pkg::TEX_ONE_FLOAT) ? 3'd1
                                                         : {1'b0, tex_bits} + 3'd2;
      d_mask[vfld_pkg::SlotTex0 + i] = ({28'd0, set_count} > i);
      d_fmt[vfld_pkg::SlotTex0 + i]  = vfld_pkg::fmt_for_floats(tex_floats);
      d_size[vfld_pkg::SlotTex0 + i] = {tex_floats, 2'b00};
    end

    // No position: a single all-zero result
    if (pos_code == vfld_pkg::POS_NONE) begin
      d_layout = 1'b0;
      d_mask   = '0;
      d_mask[vfld_pkg::SlotPos] = 1'b1;
      d_fmt[vfld_pkg::SlotPos]  = vfld_pkg::FMT_FLOAT1;
      d_size[vfld_pkg::SlotPos] = 5'd0;
    end
  end

  // Decode register
  always_ff @(posedge clk) begin
    if (rst) begin
      dec_valid <= 1'b0;
    end else if (cap_take) begin
      dec_valid <= 1'b1;
    end else if (dec_take) begin
      dec_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cap_take) begin
      dec_mask   <= d_mask;
      dec_fmt    <= d_fmt;
      dec_size   <= d_size;
      dec_layout <= d_layout;
    end
  end

  // Element walker: lowest pending slot each cycle
  logic [SlotW-1:0]    sel;
  logic [NumSlots-1:0] walk_mask_next;
  logic [7:0]          walk_stride_next;

  always_comb begin
    sel = '0;
    for (int i = NumSlots - 1; i >= 0; i--) begin
      if (walk_mask[i]) begin
        sel = SlotW'(i);
      end
    end
    walk_mask_next      = walk_mask;
    walk_mask_next[sel] = 1'b0;
    walk_last           = walk_valid && (walk_mask_next == '0);
    walk_stride_next    = walk_stride + {3'd0, walk_size[sel]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_valid <= 1'b0;
    end else if (dec_take) begin
      walk_valid <= 1'b1;
    end else if (walk_last) begin
      walk_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dec_take) begin
      walk_mask   <= dec_mask;
      walk_fmt    <= dec_fmt;
      walk_size   <= dec_size;
      walk_layout <= dec_layout;
      walk_stride <= 8'd0;
    end else if (walk_valid) begin
      walk_mask   <= walk_mask_next;
      walk_stride <= walk_stride_next;
    end
  end

  // Kind and semantic index follow from the slot
  logic [2:0] sel_kind;
  logic [2:0] sel_semantic;

  always_comb begin
    sel_semantic = 3'd0;
    case ({{(32 - SlotW){1'b0}}, sel})
      vfld_pkg::SlotPos:      sel_kind = vfld_pkg::KIND_POSITION;
      vfld_pkg::SlotWeight:   sel_kind = vfld_pkg::KIND_BLENDWEIGHT;
      vfld_pkg::SlotIndices:  sel_kind = vfld_pkg::KIND_BLENDINDICES;
      vfld_pkg::SlotNormal:   sel_kind = vfld_pkg::KIND_NORMAL;
      vfld_pkg::SlotPsize:    sel_kind = vfld_pkg::KIND_PSIZE;
      vfld_pkg::SlotDiffuse:  sel_kind = vfld_pkg::KIND_COLOR;
      vfld_pkg::SlotSpecular: begin
        sel_kind     = vfld_pkg::KIND_COLOR;
        sel_semantic = 3'd1;
      end
      default: begin
        sel_kind     = vfld_pkg::KIND_TEXCOORD;
        sel_semantic = 3'(sel - SlotW'(vfld_pkg::SlotTex0));
      end
    endcase
    if (!walk_layout) begin
      sel_kind = vfld_pkg::KIND_POSITION;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= walk_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (walk_valid) begin
      layout_valid   <= walk_layout;
      element_kind   <= sel_kind;
      semantic_slot  <= sel_semantic;
      element_format <= walk_fmt[sel];
      byte_offset    <= walk_stride;
      elem_size      <= walk_size[sel];
      total_stride   <= walk_stride_next;
      last_element   <= walk_last;
    end
  end

endmodule
